// ----- rtl/core/sfd_pkg.sv -----
// Shared constants, types and helpers for the stereo feedback delay.
`default_nettype none
package sfd_pkg;

  localparam int DEFAULT_MAX_DELAY   = 65536;
  localparam int DEFAULT_SAMPLE_BITS = 24;

  localparam int DELAY_BITS = 16;
  localparam int GAIN_BITS  = 17;
  localparam int COEF_BITS  = 16;

  localparam logic [GAIN_BITS-1:0]  UNITY_Q16     = 17'd65536;
  localparam logic [COEF_BITS-1:0]  FEEDBACK_Q16  = 16'd64881;
  localparam logic [DELAY_BITS-1:0] RESET_DELAY   = 16'd4800;

  localparam int REG_INDEX_BITS = 1;
  localparam logic [REG_INDEX_BITS-1:0] REG_LEFT_DELAY  = 1'd0;
  localparam logic [REG_INDEX_BITS-1:0] REG_RIGHT_DELAY = 1'd1;

  typedef struct packed {
    logic start;
    logic take;
  } lane_ctrl_t;

  typedef struct packed {
    logic done;
    logic cfg_busy;
  } lane_stat_t;

  function automatic logic [GAIN_BITS-1:0] clamp_unity(input logic [GAIN_BITS-1:0] v);
    clamp_unity = (v > UNITY_Q16) ? UNITY_Q16 : v;
  endfunction

endpackage
`default_nettype wire

// ----- rtl/core/sfd_lane.sv -----
// One channel of the echo: delay memory, length register and feedback datapath.
`default_nettype none
module sfd_lane #(
  parameter int MAX_DELAY   = sfd_pkg::DEFAULT_MAX_DELAY,
  parameter int SAMPLE_BITS = sfd_pkg::DEFAULT_SAMPLE_BITS
) (
  input  wire logic                                  clk,
  input  wire logic                                  rst,
  input  wire sfd_pkg::lane_ctrl_t                   ctrl,
  output sfd_pkg::lane_stat_t                        stat,
  input  wire logic [$clog2(MAX_DELAY)-1:0]          wp,
  input  wire logic [$clog2(MAX_DELAY):0]            fill,
  input  wire logic signed [SAMPLE_BITS-1:0]         sample_in,
  input  wire logic [sfd_pkg::GAIN_BITS-1:0]         amount_in,
  input  wire logic [sfd_pkg::GAIN_BITS-1:0]         mix,
  input  wire logic                                  cfg_write,
  input  wire logic [sfd_pkg::DELAY_BITS-1:0]        cfg_data,
  output logic signed [SAMPLE_BITS-1:0]              sample_out
);

  localparam int AW    = $clog2(MAX_DELAY);
  localparam int SB    = SAMPLE_BITS;
  localparam int GB    = sfd_pkg::GAIN_BITS;
  localparam int CB    = sfd_pkg::COEF_BITS;
  localparam int QSH   = sfd_pkg::DELAY_BITS + AW;
  localparam int RW    = sfd_pkg::DELAY_BITS + 2;
  localparam int PW    = sfd_pkg::DELAY_BITS + RW;

  localparam logic [63:0] RECIP_FULL =
    ((64'd1 << QSH) + 64'(MAX_DELAY) - 64'd1) / 64'(MAX_DELAY);
  localparam logic [RW-1:0] RECIP = RW'(RECIP_FULL);
  localparam logic [sfd_pkg::DELAY_BITS-1:0] DEPTH_LO = sfd_pkg::DELAY_BITS'(MAX_DELAY);
  localparam logic [AW:0]     DEPTH    = (AW+1)'(MAX_DELAY);
  localparam logic [32:0] FEEDBACK_Q16_EXT = 33'(sfd_pkg::FEEDBACK_Q16);

  localparam logic signed [SB+2:0] SMAX = (SB+3)'((64'd1 << (SB - 1)) - 64'd1);
  localparam logic signed [SB+2:0] SMIN = -SMAX - (SB+3)'(1);

  localparam logic [2:0] ST_IDLE = 3'd0;
  localparam logic [2:0] ST_READ = 3'd1;
  localparam logic [2:0] ST_MUL  = 3'd2;
  localparam logic [2:0] ST_PROD = 3'd3;
  localparam logic [2:0] ST_SUM  = 3'd4;
  localparam logic [2:0] ST_DONE = 3'd5;

  logic [SB-1:0] mem [MAX_DELAY];

  logic [2:0]                  st;
  logic [sfd_pkg::DELAY_BITS-1:0] len;
  logic [sfd_pkg::DELAY_BITS-1:0] quo;
  logic                        red_step;
  logic                        red_busy;

  logic signed [SB-1:0]   x;
  logic [GB-1:0]          amt;
  logic [GB-1:0]          mix_q;
  logic [AW-1:0]          wp_q;
  logic [AW:0]            fill_q;
  logic [AW-1:0]          rd;
  logic [CB-1:0]          coef;
  logic [SB-1:0]          rdata;
  logic                   hit;
  logic signed [SB-1:0]   wet;
  logic signed [SB+17:0]  p_dry;
  logic signed [SB+17:0]  p_wet;

  logic [PW-1:0]          quo_prod;
  logic [sfd_pkg::DELAY_BITS-1:0] rem_prod;
  logic [AW-1:0]          d;
  logic [AW:0]            rd_sum;
  logic [AW-1:0]          rd_next;
  logic [32:0]            coef_prod;
  logic signed [SB-1:0]   delayed;
  logic signed [SB+16:0]  wprod;
  logic signed [SB:0]     stored_sum;
  logic signed [SB-1:0]   stored;
  logic signed [SB+18:0]  acc;
  logic signed [SB+2:0]   acc_q;

  // Delay length reduced modulo the memory depth by a reciprocal multiply in two steps.
  always_ff @(posedge clk) begin
    if (rst) begin
      len      <= sfd_pkg::RESET_DELAY;
      red_step <= 1'b0;
      red_busy <= 1'b1;
    end else if (cfg_write) begin
      len      <= cfg_data;
      red_step <= 1'b0;
      red_busy <= 1'b1;
    end else if (red_busy) begin
      if (!red_step) begin
        quo      <= sfd_pkg::DELAY_BITS'(quo_prod >> QSH);
        red_step <= 1'b1;
      end else begin
        len      <= len - rem_prod;
        red_step <= 1'b0;
        red_busy <= 1'b0;
      end
    end
  end

  always_comb begin
    quo_prod = PW'(len) * PW'(RECIP);
    rem_prod = quo * DEPTH_LO;
    d      = AW'(len);
    rd_sum = {1'b0, wp} + DEPTH - {1'b0, d};
    if (rd_sum >= DEPTH) begin
      rd_next = AW'(rd_sum - DEPTH);
    end else begin
      rd_next = AW'(rd_sum);
    end
    coef_prod  = 33'(amt) * 33'(FEEDBACK_Q16_EXT) + 33'd32768;
    delayed    = hit ? $signed(rdata) : '0;
    wprod      = $signed({1'b0, coef}) * delayed + (SB+17)'(32768);
    stored_sum = (SB+1)'(x) + (SB+1)'(wet);
    if (stored_sum > (SB+1)'(SMAX)) begin
      stored = SB'(SMAX);
    end else if (stored_sum < (SB+1)'(SMIN)) begin
      stored = SB'(SMIN);
    end else begin
      stored = SB'(stored_sum);
    end
    acc   = (SB+19)'(p_dry) + (SB+19)'(p_wet) + (SB+19)'(32768);
    acc_q = (SB+3)'(acc >>> 16);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      st <= ST_IDLE;
    end else begin
      case (st)
        ST_IDLE: if (ctrl.start) st <= ST_READ;
        ST_READ: st <= ST_MUL;
        ST_MUL:  st <= ST_PROD;
        ST_PROD: st <= ST_SUM;
        ST_SUM:  st <= ST_DONE;
        ST_DONE: if (ctrl.take) st <= ST_IDLE;
        default: st <= ST_IDLE;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (ctrl.start && st == ST_IDLE) begin
      x      <= sample_in;
      amt    <= sfd_pkg::clamp_unity(amount_in);
      mix_q  <= mix;
      wp_q   <= wp;
      fill_q <= fill;
      rd     <= rd_next;
    end
    if (st == ST_READ) begin
      rdata <= mem[rd];
      hit   <= {1'b0, rd} < fill_q;
      coef  <= CB'(coef_prod >> 16);
    end
    if (st == ST_MUL) begin
      wet <= SB'(wprod >>> 16);
    end
    if (st == ST_PROD) begin
      mem[wp_q] <= stored;
      p_dry     <= $signed({1'b0, sfd_pkg::UNITY_Q16 - mix_q}) * x;
      p_wet     <= $signed({1'b0, mix_q}) * wet;
    end
    if (st == ST_SUM) begin
      if (acc_q > SMAX) begin
        sample_out <= SB'(SMAX);
      end else if (acc_q < SMIN) begin
        sample_out <= SB'(SMIN);
      end else begin
        sample_out <= SB'(acc_q);
      end
    end
  end

  assign stat.done     = (st == ST_DONE);
  assign stat.cfg_busy = red_busy;

endmodule
`default_nettype wire

// ----- rtl/core/stereo_feedback_delay.sv -----
// Stereo feedback delay: two channel lanes, write position and output merge register.
//
// Items enter on in_valid/in_ready and leave on out_valid/out_ready. Each item is
// one stereo sample pair with a shared mix and one feedback amount per channel.
// Both channel lanes work on the item side by side; their results are merged into
// one output register that holds the pair until the receiver takes it.
// Each item passes through the lane sequence of address, memory read, feedback
// multiply, write-back with the mix products, and the final sum, then moves into
// the output register. No new item is accepted until the lanes have handed the last
// one on. One item sits in the lanes and one in the output register, so a stalled
// receiver holds back input only once a second finished pair is waiting.
// Writing a delay length starts a reduction of that length modulo the memory depth,
// during which no item is accepted; the same runs right after reset.
// Reset empties both delay lines logically through a fill count, so no clearing
// pass is needed, and sets both delay lengths to 4800 samples.
`default_nettype none
module stereo_feedback_delay #(
  parameter int MAX_DELAY   = sfd_pkg::DEFAULT_MAX_DELAY,
  parameter int SAMPLE_BITS = sfd_pkg::DEFAULT_SAMPLE_BITS
) (
  input  wire logic                                      clk,
  input  wire logic                                      rst,
  input  wire logic                                      cfg_write,
  input  wire logic [sfd_pkg::REG_INDEX_BITS-1:0]        cfg_index,
  input  wire logic [sfd_pkg::DELAY_BITS-1:0]            cfg_data,
  input  wire logic                                      in_valid,
  output logic                                           in_ready,
  input  wire logic signed [SAMPLE_BITS-1:0]             left_in,
  input  wire logic signed [SAMPLE_BITS-1:0]             right_in,
  input  wire logic [sfd_pkg::GAIN_BITS-1:0]             mix_amount,
  input  wire logic [sfd_pkg::GAIN_BITS-1:0]             left_feedback,
  input  wire logic [sfd_pkg::GAIN_BITS-1:0]             right_feedback,
  output logic                                           out_valid,
  input  wire logic                                      out_ready,
  output logic signed [SAMPLE_BITS-1:0]                  left_out,
  output logic signed [SAMPLE_BITS-1:0]                  right_out
);

  localparam int AW = $clog2(MAX_DELAY);
  localparam logic [AW-1:0] WP_LAST = AW'(MAX_DELAY - 1);
  localparam logic [AW:0]   FILL_MAX = (AW+1)'(MAX_DELAY);

  sfd_pkg::lane_ctrl_t ctrl;
  sfd_pkg::lane_stat_t lstat;
  sfd_pkg::lane_stat_t rstat;

  logic                          busy;
  logic [AW-1:0]                 wp;
  logic [AW:0]                   fill;
  logic                          accept;
  logic [sfd_pkg::GAIN_BITS-1:0] mix_clamped;
  logic signed [SAMPLE_BITS-1:0] lane_left;
  logic signed [SAMPLE_BITS-1:0] lane_right;

  assign in_ready    = !busy && !lstat.cfg_busy && !rstat.cfg_busy;
  assign accept      = in_valid && in_ready;
  assign mix_clamped = sfd_pkg::clamp_unity(mix_amount);
  assign ctrl.start  = accept;
  assign ctrl.take   = lstat.done && rstat.done && (!out_valid || out_ready);

  sfd_lane #(.MAX_DELAY(MAX_DELAY), .SAMPLE_BITS(SAMPLE_BITS)) u_left (
    .clk        (clk),
    .rst        (rst),
    .ctrl       (ctrl),
    .stat       (lstat),
    .wp         (wp),
    .fill       (fill),
    .sample_in  (left_in),
    .amount_in  (left_feedback),
    .mix        (mix_clamped),
    .cfg_write  (cfg_write && cfg_index == sfd_pkg::REG_LEFT_DELAY),
    .cfg_data   (cfg_data),
    .sample_out (lane_left)
  );

  sfd_lane #(.MAX_DELAY(MAX_DELAY), .SAMPLE_BITS(SAMPLE_BITS)) u_right (
    .clk        (clk),
    .rst        (rst),
    .ctrl       (ctrl),
    .stat       (rstat),
    .wp         (wp),
    .fill       (fill),
    .sample_in  (right_in),
    .amount_in  (right_feedback),
    .mix        (mix_clamped),
    .cfg_write  (cfg_write && cfg_index == sfd_pkg::REG_RIGHT_DELAY),
    .cfg_data   (cfg_data),
    .sample_out (lane_right)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      busy      <= 1'b0;
      wp        <= '0;
      fill      <= '0;
      out_valid <= 1'b0;
    end else begin
      if (accept) begin
        busy <= 1'b1;
        wp   <= (wp == WP_LAST) ? '0 : wp + AW'(1);
        if (fill != FILL_MAX) begin
          fill <= fill + (AW+1)'(1);
        end
      end else if (ctrl.take) begin
        busy <= 1'b0;
      end
      if (ctrl.take) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (ctrl.take) begin
      left_out  <= lane_left;
      right_out <= lane_right;
    end
  end

`ifndef NO_ASSERTIONS
  a_lanes_in_step: assert property (@(posedge clk) disable iff (rst)
    lstat.done == rstat.done)
    else $error("channel lanes finished out of step");

  a_accept_sets_busy: assert property (@(posedge clk) disable iff (rst)
    accept |=> busy && !in_ready)
    else $error("lanes did not hold off the next item");

  a_take_loads_output: assert property (@(posedge clk) disable iff (rst)
    ctrl.take |=> out_valid && !busy)
    else $error("merged result not presented after lane handoff");

  a_fill_bounded: assert property (@(posedge clk) disable iff (rst)
    (fill <= FILL_MAX) && (wp <= WP_LAST))
    else $error("write position or fill count out of range");
`endif

endmodule
`default_nettype wire
